// ===== rtl/blle_pkg.sv =====
`default_nettype none

package blle_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int FIELD_W        = 32;

  typedef enum logic [3:0] {
    ACT_PUSH_BACK   = 4'd0,
    ACT_PUSH_FRONT  = 4'd1,
    ACT_POP_BACK    = 4'd2,
    ACT_POP_FRONT   = 4'd3,
    ACT_INSERT      = 4'd4,
    ACT_SEARCH      = 4'd5,
    ACT_SORT_UP     = 4'd6,
    ACT_SORT_DOWN   = 4'd7,
    ACT_CURSOR_HEAD = 4'd8,
    ACT_CURSOR_READ = 4'd9,
    ACT_CURSOR_NEXT = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_CUR  = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    VW_ITEM  = 2'd0,
    VW_NEW   = 2'd1,
    VW_RD    = 2'd2,
    VW_CARRY = 2'd3
  } val_sel_e;

  typedef enum logic [2:0] {
    LW_ALLOC_NULL = 3'd0,
    LW_ALLOC_HEAD = 3'd1,
    LW_ALLOC_LINK = 3'd2,
    LW_TAIL_AUX   = 3'd3,
    LW_WALK_AUX   = 3'd4,
    LW_WALK_NULL  = 3'd5
  } link_sel_e;

  typedef enum logic [1:0] {
    HD_KEEP  = 2'd0,
    HD_ALLOC = 2'd1,
    HD_NULL  = 2'd2,
    HD_LINK  = 2'd3
  } head_sel_e;

  typedef enum logic [2:0] {
    TL_KEEP  = 3'd0,
    TL_ALLOC = 3'd1,
    TL_NULL  = 3'd2,
    TL_AUX   = 3'd3,
    TL_WALK  = 3'd4
  } tail_sel_e;

  typedef enum logic [2:0] {
    CR_KEEP      = 3'd0,
    CR_HEAD      = 3'd1,
    CR_LINK      = 3'd2,
    CR_DROP_HEAD = 3'd3,
    CR_DROP_TAIL = 3'd4
  } cur_sel_e;

  typedef enum logic [1:0] {
    FR_NONE = 2'd0,
    FR_HEAD = 2'd1,
    FR_TAIL = 2'd2
  } free_sel_e;

  typedef struct packed {
    logic [3:0]                action;
    logic signed [FIELD_W-1:0] item_value;
    logic signed [FIELD_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      found;
    logic signed [FIELD_W-1:0] result_value;
    logic                      at_end;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      val_we;
    val_sel_e  val_sel;
    logic      link_we;
    link_sel_e link_sel;
    logic      alloc;
    head_sel_e head_sel;
    tail_sel_e tail_sel;
    cur_sel_e  cur_sel;
    free_sel_e free_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      carry_ld;
    logic      sort_up;
    logic      prev_ld;
    logic      pass_init;
    logic      pass_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic cnt_one;
    logic head_is_tail;
    logic cur_null;
    logic link_null;
    logic link_is_tail;
    logic val_match;
    logic walk_is_tail;
    logic carry_swap;
    logic pass_one;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/blle_dp.sv =====
`default_nettype none

module blle_dp #(
  parameter int CAPACITY   = blle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = blle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire blle_pkg::req_t                   req_i,
  input  wire blle_pkg::dp_cmd_t                cmd_i,
  output blle_pkg::dp_stat_t                    stat_o,
  output logic signed [blle_pkg::FIELD_W-1:0]   rd_val_o
);
  import blle_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

  logic signed [DATA_WIDTH-1:0] value_mem [CAPACITY];
  logic [PTR_W-1:0]             link_mem  [CAPACITY];

  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [PTR_W-1:0]    cnt_q, cnt_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic [PTR_W-1:0]    pass_q;
  logic [SLOT_W-1:0]   walk_q, prev_q, aux_q;
  logic signed [DATA_WIDTH-1:0] item_q, new_q, carry_q, rd_val_q;
  logic signed [DATA_WIDTH-1:0] item_in, new_in;
  logic [PTR_W-1:0]    rd_link_q;

  logic [SLOT_W-1:0]   alloc_slot, rd_addr, val_addr, link_addr;
  logic signed [DATA_WIDTH-1:0] val_data;
  logic [PTR_W-1:0]    link_data;

  // Narrow or widen the 32-bit fields to the stored width.
  if (DATA_WIDTH >= FIELD_W) begin : g_wide
    assign item_in  = DATA_WIDTH'(req_i.item_value);
    assign new_in   = DATA_WIDTH'(req_i.new_value);
    assign rd_val_o = rd_val_q[FIELD_W-1:0];
  end else begin : g_narrow
    assign item_in  = req_i.item_value[DATA_WIDTH-1:0];
    assign new_in   = req_i.new_value[DATA_WIDTH-1:0];
    assign rd_val_o = FIELD_W'(rd_val_q);
  end

  // Lowest free slot.
  always_comb begin
    alloc_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) alloc_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD: rd_addr = head_q[SLOT_W-1:0];
      RD_CUR:  rd_addr = cur_q[SLOT_W-1:0];
      RD_LINK: rd_addr = rd_link_q[SLOT_W-1:0];
      default: rd_addr = head_q[SLOT_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.val_sel)
      VW_ITEM: begin
        val_addr = alloc_slot;
        val_data = item_q;
      end
      VW_NEW: begin
        val_addr = alloc_slot;
        val_data = new_q;
      end
      VW_RD: begin
        val_addr = prev_q;
        val_data = rd_val_q;
      end
      default: begin
        val_addr = prev_q;
        val_data = carry_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.link_sel)
      LW_ALLOC_NULL: begin
        link_addr = alloc_slot;
        link_data = NULL_PTR;
      end
      LW_ALLOC_HEAD: begin
        link_addr = alloc_slot;
        link_data = head_q;
      end
      LW_ALLOC_LINK: begin
        link_addr = alloc_slot;
        link_data = rd_link_q;
      end
      LW_TAIL_AUX: begin
        link_addr = tail_q[SLOT_W-1:0];
        link_data = PTR_W'(aux_q);
      end
      LW_WALK_AUX: begin
        link_addr = walk_q;
        link_data = PTR_W'(aux_q);
      end
      default: begin
        link_addr = walk_q;
        link_data = NULL_PTR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.val_we) value_mem[val_addr] <= val_data;
    if (cmd_i.link_we) link_mem[link_addr] <= link_data;
    if (cmd_i.rd_en) begin
      rd_val_q  <= value_mem[rd_addr];
      rd_link_q <= link_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.head_sel)
      HD_ALLOC: head_d = PTR_W'(alloc_slot);
      HD_NULL:  head_d = NULL_PTR;
      HD_LINK:  head_d = rd_link_q;
      default:  head_d = head_q;
    endcase
    case (cmd_i.tail_sel)
      TL_ALLOC: tail_d = PTR_W'(alloc_slot);
      TL_NULL:  tail_d = NULL_PTR;
      TL_AUX:   tail_d = PTR_W'(aux_q);
      TL_WALK:  tail_d = PTR_W'(walk_q);
      default:  tail_d = tail_q;
    endcase
    case (cmd_i.cur_sel)
      CR_HEAD:      cur_d = head_q;
      CR_LINK:      cur_d = rd_link_q;
      CR_DROP_HEAD: cur_d = (cur_q == head_q) ? NULL_PTR : cur_q;
      CR_DROP_TAIL: cur_d = (cur_q == tail_q) ? NULL_PTR : cur_q;
      default:      cur_d = cur_q;
    endcase
    free_d = free_q;
    if (cmd_i.alloc) free_d[alloc_slot] = 1'b0;
    case (cmd_i.free_sel)
      FR_HEAD: free_d[head_q[SLOT_W-1:0]] = 1'b1;
      FR_TAIL: free_d[tail_q[SLOT_W-1:0]] = 1'b1;
      default: ;
    endcase
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) cnt_d = cnt_q + PTR_W'(1);
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - PTR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NULL_PTR;
      tail_q <= NULL_PTR;
      cur_q  <= NULL_PTR;
      cnt_q  <= '0;
      free_q <= '1;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cur_q  <= cur_d;
      cnt_q  <= cnt_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= item_in;
      new_q  <= new_in;
    end
    if (cmd_i.rd_en) walk_q <= rd_addr;
    if (cmd_i.prev_ld) prev_q <= walk_q;
    if (cmd_i.alloc) aux_q <= alloc_slot;
    if (cmd_i.carry_ld) carry_q <= rd_val_q;
    if (cmd_i.pass_init) pass_q <= cnt_q - PTR_W'(1);
    else if (cmd_i.pass_dec) pass_q <= pass_q - PTR_W'(1);
  end

  always_comb begin
    stat_o.empty        = (cnt_q == '0);
    stat_o.full         = (cnt_q == PTR_W'(CAPACITY));
    stat_o.cnt_one      = (cnt_q == PTR_W'(1));
    stat_o.head_is_tail = (head_q == tail_q);
    stat_o.cur_null     = (cur_q == NULL_PTR);
    stat_o.link_null    = (rd_link_q == NULL_PTR);
    stat_o.link_is_tail = (rd_link_q == tail_q);
    stat_o.val_match    = (rd_val_q == item_q);
    stat_o.walk_is_tail = (PTR_W'(walk_q) == tail_q);
    stat_o.carry_swap   = cmd_i.sort_up ? (carry_q > rd_val_q) : (carry_q < rd_val_q);
    stat_o.pass_one     = (pass_q == PTR_W'(1));
  end

endmodule

`default_nettype wire

// ===== rtl/blle_ctrl.sv =====
`default_nettype none

module blle_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [3:0]                      action_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output blle_pkg::res_t                       out_res_o,
  output blle_pkg::dp_cmd_t                    cmd_o,
  input  wire blle_pkg::dp_stat_t              stat_i,
  input  wire logic signed [blle_pkg::FIELD_W-1:0] rd_val_i
);
  import blle_pkg::*;

  localparam int K_W = $clog2(MAX_RESULTS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_POPF     = 4'd2;
  localparam logic [3:0] S_POPB     = 4'd3;
  localparam logic [3:0] S_PUSHB    = 4'd4;
  localparam logic [3:0] S_FIND     = 4'd5;
  localparam logic [3:0] S_INS      = 4'd6;
  localparam logic [3:0] S_CNEXT    = 4'd7;
  localparam logic [3:0] S_SRT_LD   = 4'd8;
  localparam logic [3:0] S_SRT_STEP = 4'd9;
  localparam logic [3:0] S_SRT_END  = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;
  localparam logic [3:0] S_RESP     = 4'd12;

  logic [3:0]     state_q, state_d;
  action_e        action_q, action_d;
  status_e        resp_status_q, resp_status_d;
  logic           resp_found_q, resp_found_d;
  logic           resp_cur_q, resp_cur_d;
  logic [K_W-1:0] k_q, k_d;
  logic           out_valid_q, out_ld, out_free, emit_last;
  res_t           out_q, out_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_last   = stat_i.link_null || (k_q == K_W'(MAX_RESULTS - 1));

  always_comb begin
    cmd_o         = '0;
    cmd_o.sort_up = (action_q == ACT_SORT_UP);
    state_d       = state_q;
    action_d      = action_q;
    resp_status_d = resp_status_q;
    resp_found_d  = resp_found_q;
    resp_cur_d    = resp_cur_q;
    k_d           = k_q;
    out_ld        = 1'b0;
    out_d         = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          action_d      = action_e'(action_i);
          state_d       = S_DISP;
        end
      end

      S_DISP: begin
        resp_status_d = ST_OK;
        resp_found_d  = 1'b0;
        resp_cur_d    = 1'b0;
        state_d       = S_RESP;
        case (action_q)
          ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (stat_i.full) begin
              resp_status_d = ST_FULL;
            end else begin
              cmd_o.alloc   = 1'b1;
              cmd_o.val_we  = 1'b1;
              cmd_o.val_sel = VW_ITEM;
              cmd_o.link_we = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              if (stat_i.empty) begin
                cmd_o.link_sel = LW_ALLOC_NULL;
                cmd_o.head_sel = HD_ALLOC;
                cmd_o.tail_sel = TL_ALLOC;
              end else if (action_q == ACT_PUSH_FRONT) begin
                cmd_o.link_sel = LW_ALLOC_HEAD;
                cmd_o.head_sel = HD_ALLOC;
              end else begin
                cmd_o.link_sel = LW_ALLOC_NULL;
                state_d        = S_PUSHB;
              end
            end
          end
          ACT_POP_BACK, ACT_POP_FRONT: begin
            if (stat_i.empty) begin
              resp_status_d = ST_EMPTY;
            end else if (stat_i.cnt_one || stat_i.head_is_tail) begin
              cmd_o.head_sel = HD_NULL;
              cmd_o.tail_sel = TL_NULL;
              cmd_o.cur_sel  = CR_DROP_HEAD;
              cmd_o.free_sel = FR_HEAD;
              cmd_o.cnt_dec  = 1'b1;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_HEAD;
              state_d      = (action_q == ACT_POP_FRONT) ? S_POPF : S_POPB;
            end
          end
          ACT_INSERT, ACT_SEARCH: begin
            if (stat_i.empty) begin
              resp_status_d = ST_EMPTY;
            end else if (stat_i.full && action_q == ACT_INSERT) begin
              resp_status_d = ST_FULL;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_HEAD;
              state_d      = S_FIND;
            end
          end
          ACT_SORT_UP, ACT_SORT_DOWN: begin
            if (stat_i.empty) begin
              resp_status_d = ST_EMPTY;
            end else begin
              cmd_o.pass_init = 1'b1;
              cmd_o.rd_en     = 1'b1;
              cmd_o.rd_sel    = RD_HEAD;
              k_d             = '0;
              state_d         = stat_i.cnt_one ? S_EMIT : S_SRT_LD;
            end
          end
          ACT_CURSOR_HEAD: begin
            if (stat_i.empty) begin
              resp_status_d = ST_EMPTY;
            end else begin
              resp_cur_d    = 1'b1;
              cmd_o.cur_sel = CR_HEAD;
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = RD_HEAD;
            end
          end
          ACT_CURSOR_READ, ACT_CURSOR_NEXT: begin
            if (stat_i.empty) begin
              resp_status_d = ST_EMPTY;
            end else begin
              resp_cur_d = 1'b1;
              if (!stat_i.cur_null) begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_CUR;
                if (action_q == ACT_CURSOR_NEXT) state_d = S_CNEXT;
              end
            end
          end
          default: ;
        endcase
      end

      S_PUSHB: begin
        cmd_o.link_we  = 1'b1;
        cmd_o.link_sel = LW_TAIL_AUX;
        cmd_o.tail_sel = TL_AUX;
        state_d        = S_RESP;
      end

      S_POPF: begin
        cmd_o.head_sel = HD_LINK;
        cmd_o.cur_sel  = CR_DROP_HEAD;
        cmd_o.free_sel = FR_HEAD;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_RESP;
      end

      S_POPB: begin
        // Walk until the entry that links to the tail.
        if (stat_i.link_is_tail) begin
          cmd_o.link_we  = 1'b1;
          cmd_o.link_sel = LW_WALK_NULL;
          cmd_o.tail_sel = TL_WALK;
          cmd_o.cur_sel  = CR_DROP_TAIL;
          cmd_o.free_sel = FR_TAIL;
          cmd_o.cnt_dec  = 1'b1;
          state_d        = S_RESP;
        end else if (stat_i.link_null) begin
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
        end
      end

      S_FIND: begin
        if (stat_i.val_match) begin
          if (action_q == ACT_SEARCH) begin
            resp_found_d = 1'b1;
            state_d      = S_RESP;
          end else begin
            cmd_o.alloc    = 1'b1;
            cmd_o.val_we   = 1'b1;
            cmd_o.val_sel  = VW_NEW;
            cmd_o.link_we  = 1'b1;
            cmd_o.link_sel = LW_ALLOC_LINK;
            cmd_o.cnt_inc  = 1'b1;
            state_d        = S_INS;
          end
        end else if (stat_i.link_null) begin
          if (action_q != ACT_SEARCH) resp_status_d = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
        end
      end

      S_INS: begin
        cmd_o.link_we  = 1'b1;
        cmd_o.link_sel = LW_WALK_AUX;
        cmd_o.tail_sel = stat_i.walk_is_tail ? TL_AUX : TL_KEEP;
        state_d        = S_RESP;
      end

      S_CNEXT: begin
        cmd_o.cur_sel = CR_LINK;
        if (!stat_i.link_null) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
        end
        state_d = S_RESP;
      end

      S_SRT_LD: begin
        cmd_o.carry_ld = 1'b1;
        cmd_o.prev_ld  = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_LINK;
        state_d        = S_SRT_STEP;
      end

      S_SRT_STEP: begin
        // Bubble pass: drop the lesser-ranked value behind, carry the other on.
        cmd_o.val_we   = 1'b1;
        cmd_o.val_sel  = stat_i.carry_swap ? VW_RD : VW_CARRY;
        cmd_o.carry_ld = !stat_i.carry_swap;
        cmd_o.prev_ld  = 1'b1;
        if (stat_i.link_null) begin
          state_d = S_SRT_END;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LINK;
        end
      end

      S_SRT_END: begin
        cmd_o.val_we   = 1'b1;
        cmd_o.val_sel  = VW_CARRY;
        cmd_o.pass_dec = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_HEAD;
        k_d            = '0;
        state_d        = stat_i.pass_one ? S_EMIT : S_SRT_LD;
      end

      S_EMIT: begin
        if (out_free) begin
          out_ld             = 1'b1;
          out_d.status       = ST_OK;
          out_d.result_value = rd_val_i;
          out_d.at_end       = stat_i.cur_null;
          out_d.last         = emit_last;
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_LINK;
            k_d          = k_q + K_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_ld             = 1'b1;
          out_d.status       = resp_status_q;
          out_d.found        = resp_found_q;
          out_d.result_value = (resp_cur_q && !stat_i.cur_null) ? rd_val_i : '0;
          out_d.at_end       = stat_i.cur_null;
          out_d.last         = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      action_q      <= ACT_PUSH_BACK;
      resp_status_q <= ST_OK;
      resp_found_q  <= 1'b0;
      resp_cur_q    <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      action_q      <= action_d;
      resp_status_q <= resp_status_d;
      resp_found_q  <= resp_found_d;
      resp_cur_q    <= resp_cur_d;
      k_q           <= k_d;
      if (out_ld) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== rtl/bounded_linked_list_engine.sv =====
// Bounded singly linked list of up to CAPACITY signed values.
// Input channel: in_valid_i / in_stall_o with one request per transaction
// (action, item_value, new_value). A transaction completes on a rising edge
// with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with one result per transaction
// (status, found, result_value, at_end, last). Every request yields one
// result, except a sort of a non-empty list, which yields one result per
// entry (at most 32), the final one marked by last.
// One request is in flight at a time; in_stall_o is high until its final
// result has been loaded into the output register, so the next request can
// enter while that result still waits to be taken.
// Pop from the back, search and insert after a match walk the list one link
// per cycle through the slot memory's registered read port; sort runs bubble
// passes over the list before its first result, then gives one result per
// cycle while the output is not stalled.
// Reset empties the list (all slots free, head, tail and cursor null).
// A stalled result holds in the output register and the sequencer waits.
`default_nettype none

module bounded_linked_list_engine #(
  parameter int CAPACITY   = blle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = blle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire blle_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output blle_pkg::res_t      out_res_o
);
  import blle_pkg::*;

  dp_cmd_t                   cmd;
  dp_stat_t                  stat;
  logic signed [FIELD_W-1:0] rd_val;

  // Sequencer: decodes the action and steps through list walks and sorts.
  blle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (in_req_i.action),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .rd_val_i    (rd_val)
  );

  // Slot and link memories, free map, head/tail/cursor pointers, count.
  blle_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (in_req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .rd_val_o (rd_val)
  );

endmodule

`default_nettype wire

// ===== rtl/blle_checker.sv =====
`default_nettype none

module blle_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire blle_pkg::res_t out_res_o
);
  import blle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status != ST_OK) |-> out_res_o.last && !out_res_o.found)
    else $error("error result not a single final result");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.found |-> (out_res_o.status == ST_OK) && out_res_o.last)
    else $error("found flag on bad result");

endmodule

bind bounded_linked_list_engine blle_checker u_blle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
